// ===== src/waveform_minmax_pixel_sampler_defines.svh =====
// ----------------------------------------------------------------------------
// Waveform min/max pixel sampler: assertion macros
// Shared concurrent assertion helpers, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_MINMAX_PIXEL_SAMPLER_DEFINES_SVH
`define WAVEFORM_MINMAX_PIXEL_SAMPLER_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define WMPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define WMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/wmps_pkg.sv =====
// ----------------------------------------------------------------------------
// Waveform min/max pixel sampler package
// Field layout, register indexes, state codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wmps_pkg;

  // Divider operand widths: timeline frame (32) times sample rate (19)
  localparam int DIVD_W = 51;
  localparam int DIVS_W = 17;
  localparam int DCNT_W = 6;

  // Configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_RATE     = 2'd0;
  localparam logic [1:0] CFG_FRAMES_PER_PEAK = 2'd1;
  localparam logic [1:0] CFG_PEAK_COUNT      = 2'd2;
  localparam logic [1:0] CFG_TIMELINE_FPS    = 2'd3;

  // Item kinds carried on tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Input tdata layout
  localparam int IN_TDATA_W = 144;
  localparam int OFS_ADDR   = 0;
  localparam int OFS_PMIN   = 12;
  localparam int OFS_PMAX   = 28;
  localparam int OFS_SRC    = 44;
  localparam int OFS_DUR    = 76;
  localparam int OFS_WIDTH  = 108;
  localparam int OFS_PIX    = 124;

  // Output tdata layout
  localparam int OUT_TDATA_W = 48;

  // Division steps of one query
  localparam logic [2:0] PH_FIRST_TL = 3'd0;
  localparam logic [2:0] PH_LAST_TL  = 3'd1;
  localparam logic [2:0] PH_FIRST_SF = 3'd2;
  localparam logic [2:0] PH_LAST_SF  = 3'd3;
  localparam logic [2:0] PH_FIRST_PK = 3'd4;
  localparam logic [2:0] PH_LAST_PK  = 3'd5;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_GO   = 6'b000100,
    S_DIV  = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== src/waveform_minmax_pixel_sampler.sv =====
// Load transaction: the entry is written at the accepting edge.
// Query: six divisions on one shared radix-2 divider, then a scan of the
// selected range of peak entries through the store's read port.
// One item at a time; a finished result waits in the output register.
// Invalid query: no divisions, it goes straight to the done state. Reset is
// synchronous, active low; the peak store is not cleared.
// ----------------------------------------------------------------------------
// Waveform min/max pixel sampler
// Maps a display pixel to a range of stored peak entries and returns the
// minimum of minima and maximum of maxima over that range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "waveform_minmax_pixel_sampler_defines.svh"

module waveform_minmax_pixel_sampler #(
  parameter int PEAK_DEPTH = 4096,
  parameter int MAX_PIXELS = 8192
) (
  input  logic         clk,
  input  logic         rst_n,
  // tuser: mode
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: peak_address, peak_minimum, peak_maximum, source_in_frame,
  //        duration_frames, pixel_width, pixel_index, zero pad
  input  logic [wmps_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]   in_tuser,
  // tdata: column, column_minimum, column_maximum, zero pad
  // tuser: valid_res
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [wmps_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [0:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [18:0]  cfg_wdata
);

  localparam int AW    = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
  localparam int CNT_W = $clog2(PEAK_DEPTH + 1);
  localparam int DW    = wmps_pkg::DIVD_W;
  localparam int SW    = wmps_pkg::DIVS_W;

  // configuration registers
  logic [18:0] rate_r;
  logic [15:0] fpp_r;
  logic [12:0] pcnt_r;
  logic [9:0]  fps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 19'd48000;
      fpp_r  <= 16'd256;
      pcnt_r <= 13'd0;
      fps_r  <= 10'd30;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wmps_pkg::CFG_SAMPLE_RATE:     rate_r <= cfg_wdata;
        wmps_pkg::CFG_FRAMES_PER_PEAK: fpp_r  <= cfg_wdata[15:0];
        wmps_pkg::CFG_PEAK_COUNT:      pcnt_r <= cfg_wdata[12:0];
        wmps_pkg::CFG_TIMELINE_FPS:    fps_r  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic        in_mode;
  logic [11:0] in_addr;
  logic [31:0] in_src, in_dur;
  logic [15:0] in_width;
  logic [12:0] in_pix;
  logic [31:0] in_pmin_pmax;

  assign in_mode      = in_tuser[0];
  assign in_addr      = in_tdata[wmps_pkg::OFS_ADDR +: 12];
  assign in_pmin_pmax = {in_tdata[wmps_pkg::OFS_PMAX +: 16], in_tdata[wmps_pkg::OFS_PMIN +: 16]};
  assign in_src       = in_tdata[wmps_pkg::OFS_SRC +: 32];
  assign in_dur       = in_tdata[wmps_pkg::OFS_DUR +: 32];
  assign in_width     = in_tdata[wmps_pkg::OFS_WIDTH +: 16];
  assign in_pix       = in_tdata[wmps_pkg::OFS_PIX +: 13];

  // derived settings
  logic [CNT_W-1:0] count;
  logic [AW-1:0]    cntm1;
  logic [16:0]      wclamp;
  logic [9:0]       fps_eff;
  logic             q_ok;

  always_comb begin
    if (32'(pcnt_r) > 32'(PEAK_DEPTH)) begin
      count = CNT_W'(PEAK_DEPTH);
    end else begin
      count = CNT_W'(pcnt_r);
    end
    cntm1 = AW'(count - 1'b1);
    if (32'(in_width) > 32'(MAX_PIXELS)) begin
      wclamp = 17'(MAX_PIXELS);
    end else begin
      wclamp = 17'(in_width);
    end
    fps_eff = (fps_r == '0) ? 10'd1 : fps_r;
    q_ok = (rate_r != '0) && (fpp_r != '0) && (count != '0) &&
           !in_dur[31] && (in_dur != '0) && (wclamp != '0) &&
           (17'(in_pix) < wclamp);
  end

  // control and datapath registers
  wmps_pkg::state_t state_r, state_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic [30:0]   s_r, d_r;
  logic [12:0]   pix_r;
  logic [16:0]   w_r;
  logic [31:0]   first_tl_r, last_tl_r;
  logic [DW-1:0] first_sf_r, last_sf_r;
  logic [AW-1:0] first_pk_r, last_pk_r, scan_addr_r;
  logic          issue_r, pend_r, init_r;
  logic signed [15:0] mn_r, mx_r;
  logic          vres_r;
  logic [DW-1:0] div_a_r;
  logic [SW-1:0] div_b_r;

  logic          out_valid_r;
  logic [12:0]   out_col_r;
  logic [15:0]   out_min_r, out_max_r;
  logic          out_vres_r;

  logic          in_acc, wr_en, div_start, out_load;
  logic [31:0]   rd_data;
  logic [31:0]   mul_a;
  logic [18:0]   mul_b;
  logic [DW-1:0] prod, dvd;
  logic [SW-1:0] dvs;
  logic [DW-1:0] quo;
  wmps_pkg::div_stat_t div_stat;
  logic [DW-1:0] sf_inc;
  logic [AW-1:0] pk_clamp, lp;

  assign in_tready = (state_r == wmps_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && (in_mode == wmps_pkg::MODE_LOAD) &&
                     (32'(in_addr) < 32'(PEAK_DEPTH));
  assign div_start = (state_r == wmps_pkg::S_GO);
  assign out_load  = (state_r == wmps_pkg::S_DONE) && (!out_valid_r || out_tready);

  // operand selection and product for the current step
  always_comb begin
    unique case (ph_r)
      wmps_pkg::PH_FIRST_TL: begin mul_a = 32'(d_r);   mul_b = 19'(pix_r); end
      wmps_pkg::PH_LAST_TL:  begin mul_a = 32'(d_r);   mul_b = 19'(14'(pix_r) + 14'd1); end
      wmps_pkg::PH_FIRST_SF: begin mul_a = first_tl_r; mul_b = rate_r; end
      wmps_pkg::PH_LAST_SF:  begin mul_a = last_tl_r;  mul_b = rate_r; end
      default:               begin mul_a = '0;         mul_b = '0; end
    endcase
    prod = DW'(mul_a) * DW'(mul_b);
    unique case (ph_r)
      wmps_pkg::PH_FIRST_PK: dvd = first_sf_r;
      wmps_pkg::PH_LAST_PK:  dvd = last_sf_r - 1'b1;
      default:               dvd = prod;
    endcase
    unique case (ph_r)
      wmps_pkg::PH_FIRST_TL, wmps_pkg::PH_LAST_TL: dvs = w_r;
      wmps_pkg::PH_FIRST_SF, wmps_pkg::PH_LAST_SF: dvs = SW'(fps_eff);
      default:                                     dvs = SW'(fpp_r);
    endcase
  end

  // quotient post-processing
  always_comb begin
    sf_inc = first_sf_r + 1'b1;
    if (quo > DW'(cntm1)) begin
      pk_clamp = cntm1;
    end else begin
      pk_clamp = AW'(quo);
    end
    lp = (pk_clamp < first_pk_r) ? first_pk_r : pk_clamp;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    unique case (state_r)
      wmps_pkg::S_IDLE: begin
        if (in_acc && (in_mode == wmps_pkg::MODE_QUERY)) begin
          ph_nxt    = wmps_pkg::PH_FIRST_TL;
          state_nxt = q_ok ? wmps_pkg::S_PREP : wmps_pkg::S_DONE;
        end
      end
      wmps_pkg::S_PREP: state_nxt = wmps_pkg::S_GO;
      wmps_pkg::S_GO:   state_nxt = wmps_pkg::S_DIV;
      wmps_pkg::S_DIV: begin
        if (div_stat.done) begin
          if (ph_r == wmps_pkg::PH_LAST_PK) begin
            state_nxt = wmps_pkg::S_SCAN;
          end else begin
            ph_nxt    = ph_r + 1'b1;
            state_nxt = wmps_pkg::S_PREP;
          end
        end
      end
      wmps_pkg::S_SCAN: begin
        if (!issue_r && pend_r) begin
          state_nxt = wmps_pkg::S_DONE;
        end
      end
      wmps_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = wmps_pkg::S_IDLE;
        end
      end
      default: state_nxt = wmps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmps_pkg::S_IDLE;
      ph_r        <= wmps_pkg::PH_FIRST_TL;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      // scan read pipeline
      if (state_r == wmps_pkg::S_DIV && div_stat.done && ph_r == wmps_pkg::PH_LAST_PK) begin
        issue_r <= 1'b1;
        pend_r  <= 1'b0;
      end else if (state_r == wmps_pkg::S_SCAN) begin
        pend_r <= issue_r;
        if (issue_r && scan_addr_r == last_pk_r) begin
          issue_r <= 1'b0;
        end
      end
      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && (in_mode == wmps_pkg::MODE_QUERY)) begin
      s_r    <= in_src[31] ? 31'd0 : in_src[30:0];
      d_r    <= in_dur[30:0];
      pix_r  <= in_pix;
      w_r    <= wclamp;
      vres_r <= q_ok;
      mn_r   <= '0;
      mx_r   <= '0;
    end
    if (state_r == wmps_pkg::S_PREP) begin
      div_a_r <= dvd;
      div_b_r <= dvs;
    end
    if (state_r == wmps_pkg::S_DIV && div_stat.done) begin
      unique case (ph_r)
        wmps_pkg::PH_FIRST_TL: first_tl_r <= 32'(s_r) + 32'(quo[30:0]);
        wmps_pkg::PH_LAST_TL:  last_tl_r  <= 32'(s_r) + 32'(quo[30:0]);
        wmps_pkg::PH_FIRST_SF: first_sf_r <= quo;
        wmps_pkg::PH_LAST_SF:  last_sf_r  <= (quo < sf_inc) ? sf_inc : quo;
        wmps_pkg::PH_FIRST_PK: first_pk_r <= pk_clamp;
        wmps_pkg::PH_LAST_PK: begin
          last_pk_r   <= lp;
          scan_addr_r <= first_pk_r;
          init_r      <= 1'b1;
        end
        default: ;
      endcase
    end
    // accumulate over the peak range
    if (state_r == wmps_pkg::S_SCAN) begin
      if (issue_r && scan_addr_r != last_pk_r) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
      if (pend_r) begin
        init_r <= 1'b0;
        if (init_r || $signed(rd_data[15:0]) < mn_r) begin
          mn_r <= $signed(rd_data[15:0]);
        end
        if (init_r || $signed(rd_data[31:16]) > mx_r) begin
          mx_r <= $signed(rd_data[31:16]);
        end
      end
    end
    if (out_load) begin
      out_col_r  <= pix_r;
      out_min_r  <= mn_r;
      out_max_r  <= mx_r;
      out_vres_r <= vres_r;
    end
  end

  // pixel column echo for the invalid path comes from the accept as well
  wmps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .quotient (quo),
    .stat     (div_stat)
  );

  wmps_mem #(
    .DEPTH (PEAK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_addr)),
    .wr_data (in_pmin_pmax),
    .rd_en   ((state_r == wmps_pkg::S_SCAN) && issue_r),
    .rd_addr (scan_addr_r),
    .rd_data (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_max_r, out_min_r, out_col_r};
  assign out_tuser  = out_vres_r;

  // assertions
  `WMPS_ASSERT_IMP(a_scan_range, state_r == wmps_pkg::S_SCAN, (first_pk_r <= last_pk_r) && (last_pk_r <= cntm1), "peak range out of order")
  `WMPS_ASSERT_IMP(a_scan_addr, (state_r == wmps_pkg::S_SCAN) && issue_r, scan_addr_r <= last_pk_r, "scan address beyond range")
  `WMPS_ASSERT_IMP(a_div_idle, div_start, !div_stat.busy, "divider started while busy")
  `WMPS_ASSERT_NEXT(a_done_next, div_stat.done, !div_stat.done, "divider done held")

endmodule

// ===== src/wmps_mem.sv =====
// ----------------------------------------------------------------------------
// Peak store
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmps_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem_r [DEPTH];
  logic [31:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/wmps_div.sv =====
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Unsigned quotient of a 51-bit dividend by a 17-bit non-zero divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmps_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wmps_pkg::DIVD_W-1:0] dividend,
  input  logic [wmps_pkg::DIVS_W-1:0] divisor,
  output logic [wmps_pkg::DIVD_W-1:0] quotient,
  output wmps_pkg::div_stat_t         stat
);

  logic [wmps_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [wmps_pkg::DIVS_W-1:0] rem_r, rem_nxt;
  logic [wmps_pkg::DIVS_W-1:0] dvs_r;
  logic [wmps_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [wmps_pkg::DIVS_W:0]   trial;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[wmps_pkg::DIVD_W-1]};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = wmps_pkg::DCNT_W'(wmps_pkg::DIVD_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = wmps_pkg::DIVS_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[wmps_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = wmps_pkg::DIVS_W'(trial);
        quo_nxt = {quo_r[wmps_pkg::DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
